/* rtl/cswl_pkg.sv */
package cswl_pkg;

    localparam int POOL_NODES_DEF = 64;
    localparam int NUM_SEMS_DEF   = 16;

    localparam int ACTION_W = 2;
    localparam int SEM_W    = 4;
    localparam int IVAL_W   = 15;
    localparam int TID_W    = 8;
    localparam int COUNT_W  = 16;

    localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INIT    = 2'd0,
        ACT_DESTROY = 2'd1,
        ACT_WAIT    = 2'd2,
        ACT_POST    = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_POP,
        ST_WALK
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic read_sem;
        logic wr_init;
        logic wr_wait_count;
        logic wr_wait_push;
        logic fail_pool;
        logic wr_post_count;
        logic rd_head;
        logic wr_pop;
        logic destroy_start;
        logic walk_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        act_t action;
        logic sem_ok;
        logic wait_neg;
        logic pool_ok;
        logic post_wake;
        logic destroy_has;
        logic walk_more;
    } dp_stat_t;

endpackage

/* rtl/cswl_ctrl.sv */
module cswl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cswl_pkg::dp_stat_t stat,
    output cswl_pkg::dp_cmd_t  cmd,
    output logic               busy
);
    import cswl_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                if (stat.sem_ok)
                begin
                    if (stat.action == ACT_POST && stat.post_wake)
                    begin
                        state_next = ST_POP;
                    end
                    else if (stat.action == ACT_DESTROY && stat.destroy_has)
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_POP:
            begin
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (!stat.walk_more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = start;
            end
            ST_READ:
            begin
                cmd.read_sem = 1'b1;
            end
            ST_EXEC:
            begin
                if (!stat.sem_ok)
                begin
                    cmd.finish = 1'b1;
                end
                else
                begin
                    unique case (stat.action)
                        ACT_INIT:
                        begin
                            cmd.wr_init = 1'b1;
                            cmd.finish  = 1'b1;
                        end
                        ACT_DESTROY:
                        begin
                            cmd.destroy_start = 1'b1;
                            cmd.finish        = !stat.destroy_has;
                        end
                        ACT_WAIT:
                        begin
                            cmd.finish = 1'b1;
                            priority if (!stat.wait_neg)
                            begin
                                cmd.wr_wait_count = 1'b1;
                            end
                            else if (stat.pool_ok)
                            begin
                                cmd.wr_wait_push = 1'b1;
                            end
                            else
                            begin
                                cmd.fail_pool = 1'b1;
                            end
                        end
                        ACT_POST:
                        begin
                            if (stat.post_wake)
                            begin
                                cmd.rd_head = 1'b1;
                            end
                            else
                            begin
                                cmd.wr_post_count = 1'b1;
                                cmd.finish        = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                cmd.wr_pop = 1'b1;
                cmd.finish = 1'b1;
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                cmd.finish    = !stat.walk_more;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* rtl/cswl_datapath.sv */
module cswl_datapath #(
    parameter int POOL_NODES = cswl_pkg::POOL_NODES_DEF,
    parameter int NUM_SEMS   = cswl_pkg::NUM_SEMS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cswl_pkg::dp_cmd_t            cmd,
    input  logic [cswl_pkg::ACTION_W-1:0] action,
    input  logic [cswl_pkg::SEM_W-1:0]    sem_index,
    input  logic [cswl_pkg::IVAL_W-1:0]   init_value,
    input  logic [cswl_pkg::TID_W-1:0]    thread_id,
    output cswl_pkg::dp_stat_t           stat,
    output logic                         done,
    output logic                         blocked,
    output logic                         woke,
    output logic [cswl_pkg::TID_W-1:0]    woken_thread,
    output logic                         status
);
    import cswl_pkg::*;

    localparam int NODE_W = $clog2(POOL_NODES);
    localparam int LINK_W = $clog2(POOL_NODES + 1);
    localparam int SEM_AW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int IDX_W  = (SEM_AW > SEM_W) ? SEM_AW : SEM_W;
    localparam logic [LINK_W-1:0] EMPTY    = LINK_W'(POOL_NODES);
    localparam logic [LINK_W:0]   POOL_LIM = (LINK_W + 1)'(POOL_NODES);
    localparam logic [IDX_W:0]    SEM_LIM  = (IDX_W + 1)'(NUM_SEMS);

    // captured item
    act_t              act_reg;
    logic [SEM_W-1:0]  idx_reg;
    logic [IVAL_W-1:0] ival_reg;
    logic [TID_W-1:0]  tid_reg;

    // memories
    logic signed [COUNT_W-1:0] sem_count_mem [NUM_SEMS];
    logic [LINK_W-1:0]         sem_head_mem  [NUM_SEMS];
    logic [LINK_W-1:0]         link_mem      [POOL_NODES];
    logic [TID_W-1:0]          thread_mem    [POOL_NODES];

    logic signed [COUNT_W-1:0] sem_count_rd;
    logic [LINK_W-1:0]         sem_head_rd;
    logic                      sem_hit_reg;
    logic [NUM_SEMS-1:0]       sem_valid_reg;
    logic [LINK_W-1:0]         link_rd_mem;
    logic [LINK_W-1:0]         link_rd_next;
    logic                      link_rd_fresh;
    logic [TID_W-1:0]          thread_rd;

    logic [LINK_W-1:0] pool_head_reg;
    logic [LINK_W-1:0] pool_head_next;
    logic [LINK_W-1:0] fresh_reg;
    logic [LINK_W-1:0] fresh_next;
    logic [LINK_W-1:0] walk_n_reg;
    logic [LINK_W-1:0] walk_n_next;
    logic [LINK_W-1:0] walk_cnt_reg;
    logic [LINK_W-1:0] walk_cnt_next;

    logic [IDX_W-1:0]  idx_wide;
    logic [SEM_AW-1:0] sem_addr;
    logic              sem_ok;

    logic signed [COUNT_W-1:0] cnt_eff;
    logic signed [COUNT_W-1:0] nc_wait;
    logic signed [COUNT_W-1:0] nc_post;
    logic [LINK_W-1:0]         head_eff;
    logic [LINK_W-1:0]         link_eff;
    logic [LINK_W:0]           walk_cnt_inc;

    logic                      sem_we;
    logic signed [COUNT_W-1:0] sem_wcount;
    logic [LINK_W-1:0]         sem_whead;
    logic                      link_re;
    logic [LINK_W-1:0]         link_raddr;
    logic                      link_we;
    logic [LINK_W-1:0]         link_waddr;
    logic [LINK_W-1:0]         link_wdata;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= act_t'(action);
            idx_reg  <= sem_index;
            ival_reg <= init_value;
            tid_reg  <= thread_id;
        end
    end

    assign idx_wide = IDX_W'(idx_reg);
    assign sem_addr = idx_wide[SEM_AW-1:0];
    assign sem_ok   = ({1'b0, idx_wide} < SEM_LIM);

    assign cnt_eff  = sem_hit_reg ? sem_count_rd : '0;
    assign head_eff = sem_hit_reg ? sem_head_rd : EMPTY;
    assign link_eff = link_rd_fresh ? link_rd_next : link_rd_mem;

    assign nc_wait = (cnt_eff != COUNT_MIN) ? cnt_eff - 16'sd1 : cnt_eff;
    assign nc_post = (cnt_eff != COUNT_MAX) ? cnt_eff + 16'sd1 : cnt_eff;

    assign walk_cnt_inc = {1'b0, walk_cnt_reg} + 1'b1;

    always_comb
    begin
        stat.action      = act_reg;
        stat.sem_ok      = sem_ok;
        stat.wait_neg    = nc_wait[COUNT_W-1];
        stat.pool_ok     = (pool_head_reg < EMPTY);
        stat.post_wake   = (nc_post[COUNT_W-1] || nc_post == '0) && (head_eff < EMPTY);
        stat.destroy_has = (head_eff < EMPTY);
        stat.walk_more   = (link_eff < EMPTY) && (walk_cnt_inc < POOL_LIM);
    end

    // semaphore store
    always_comb
    begin
        sem_we     = 1'b1;
        sem_wcount = cnt_eff;
        sem_whead  = head_eff;
        priority if (cmd.wr_init)
        begin
            sem_wcount = COUNT_W'({1'b0, ival_reg});
            sem_whead  = EMPTY;
        end
        else if (cmd.wr_wait_count)
        begin
            sem_wcount = nc_wait;
        end
        else if (cmd.wr_wait_push)
        begin
            sem_wcount = nc_wait;
            sem_whead  = pool_head_reg;
        end
        else if (cmd.wr_post_count)
        begin
            sem_wcount = nc_post;
        end
        else if (cmd.wr_pop)
        begin
            sem_wcount = nc_post;
            sem_whead  = link_eff;
        end
        else if (cmd.destroy_start)
        begin
            sem_whead = EMPTY;
        end
        else
        begin
            sem_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sem_we)
        begin
            sem_count_mem[sem_addr] <= sem_wcount;
            sem_head_mem[sem_addr]  <= sem_whead;
        end
        if (cmd.read_sem)
        begin
            sem_count_rd <= sem_count_mem[sem_addr];
            sem_head_rd  <= sem_head_mem[sem_addr];
        end
    end

    // node links
    always_comb
    begin
        link_re    = 1'b1;
        link_raddr = pool_head_reg;
        priority if (cmd.read_sem)
        begin
            link_raddr = pool_head_reg;
        end
        else if (cmd.rd_head || cmd.destroy_start)
        begin
            link_raddr = head_eff;
        end
        else if (cmd.walk_step)
        begin
            link_raddr = link_eff;
        end
        else
        begin
            link_re = 1'b0;
        end
    end

    always_comb
    begin
        link_we    = 1'b1;
        link_waddr = pool_head_reg;
        link_wdata = head_eff;
        priority if (cmd.wr_wait_push)
        begin
            link_waddr = pool_head_reg;
            link_wdata = head_eff;
        end
        else if (cmd.wr_pop)
        begin
            link_waddr = head_eff;
            link_wdata = pool_head_reg;
        end
        else if (cmd.walk_step)
        begin
            link_waddr = walk_n_reg;
            link_wdata = pool_head_reg;
        end
        else
        begin
            link_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr[NODE_W-1:0]] <= link_wdata;
        end
        if (link_re)
        begin
            link_rd_mem   <= link_mem[link_raddr[NODE_W-1:0]];
            link_rd_next  <= link_raddr + 1'b1;
            link_rd_fresh <= (link_raddr >= fresh_reg);
        end
    end

    // node threads
    always_ff @(posedge clk)
    begin
        if (cmd.wr_wait_push)
        begin
            thread_mem[pool_head_reg[NODE_W-1:0]] <= tid_reg;
        end
        if (cmd.rd_head)
        begin
            thread_rd <= thread_mem[head_eff[NODE_W-1:0]];
        end
    end

    // pool and walk control
    always_comb
    begin
        pool_head_next = pool_head_reg;
        fresh_next     = fresh_reg;
        walk_n_next    = walk_n_reg;
        walk_cnt_next  = walk_cnt_reg;
        if (cmd.wr_wait_push)
        begin
            pool_head_next = link_eff;
            if (pool_head_reg == fresh_reg)
            begin
                fresh_next = fresh_reg + 1'b1;
            end
        end
        if (cmd.wr_pop)
        begin
            pool_head_next = head_eff;
        end
        if (cmd.destroy_start)
        begin
            walk_n_next   = head_eff;
            walk_cnt_next = '0;
        end
        if (cmd.walk_step)
        begin
            pool_head_next = walk_n_reg;
            walk_n_next    = link_eff;
            walk_cnt_next  = walk_cnt_inc[LINK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_head_reg <= '0;
            fresh_reg     <= '0;
            walk_n_reg    <= EMPTY;
            walk_cnt_reg  <= '0;
            sem_valid_reg <= '0;
            sem_hit_reg   <= 1'b0;
            done          <= 1'b0;
        end
        else
        begin
            pool_head_reg <= pool_head_next;
            fresh_reg     <= fresh_next;
            walk_n_reg    <= walk_n_next;
            walk_cnt_reg  <= walk_cnt_next;
            if (sem_we)
            begin
                sem_valid_reg[sem_addr] <= 1'b1;
            end
            if (cmd.read_sem)
            begin
                sem_hit_reg <= sem_ok && sem_valid_reg[sem_addr];
            end
            done <= cmd.finish;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            blocked      <= cmd.wr_wait_push;
            woke         <= cmd.wr_pop;
            woken_thread <= cmd.wr_pop ? thread_rd : '0;
            status       <= cmd.fail_pool;
        end
    end

endmodule

/* rtl/counting_semaphore_wait_list_top.sv */
// done is registered from a transfer's last state: EXEC, or POP for a post that
//   wakes a waiter, or the last WALK step for a destroy that frees nodes
// flow: one item in flight; busy falls as done rises
// reset: async active low; counts zero, lists empty, pool chained from node 0
// results are shown for one cycle on done; the receiver cannot stall
module counting_semaphore_wait_list_top #(
    parameter int POOL_NODES = cswl_pkg::POOL_NODES_DEF,
    parameter int NUM_SEMS   = cswl_pkg::NUM_SEMS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cswl_pkg::ACTION_W-1:0] action,
    input  logic [cswl_pkg::SEM_W-1:0]    sem_index,
    input  logic [cswl_pkg::IVAL_W-1:0]   init_value,
    input  logic [cswl_pkg::TID_W-1:0]    thread_id,
    output logic                          done,
    output logic                          blocked,
    output logic                          woke,
    output logic [cswl_pkg::TID_W-1:0]    woken_thread,
    output logic                          status
);
    import cswl_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    cswl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    cswl_datapath #(
        .POOL_NODES (POOL_NODES),
        .NUM_SEMS   (NUM_SEMS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .action       (action),
        .sem_index    (sem_index),
        .init_value   (init_value),
        .thread_id    (thread_id),
        .stat         (stat),
        .done         (done),
        .blocked      (blocked),
        .woke         (woke),
        .woken_thread (woken_thread),
        .status       (status)
    );

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transfer in progress");

    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({blocked, woke, status}))
        else $error("more than one outcome flag set");

    a_thread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !woke) |-> (woken_thread == '0))
        else $error("woken thread set without wake");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");
`endif

endmodule

/* tb/counting_semaphore_wait_list_top_test.sv */
`timescale 1ns / 100ps

module counting_semaphore_wait_list_top_test;

    import cswl_pkg::*;

    localparam int POOL = POOL_NODES_DEF;
    localparam int SEMS = NUM_SEMS_DEF;
    localparam logic [6:0] EMPTY_NODE = 7'(POOL);
    localparam int LEAK_LIMIT = 12;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic       blocked;
        logic       woke;
        logic [7:0] woken_thread;
        logic       status;
    } sem_result_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [ACTION_W-1:0] action;
    logic [SEM_W-1:0]    sem_index;
    logic [IVAL_W-1:0]   init_value;
    logic [TID_W-1:0]    thread_id;
    logic                done;
    logic                blocked;
    logic                woke;
    logic [TID_W-1:0]    woken_thread;
    logic                status;

    // shadow of the semaphore bank
    logic signed [COUNT_W-1:0] sem_count [SEMS];
    logic [6:0]                wait_head [SEMS];
    logic [6:0]                node_next [POOL];
    logic [7:0]                node_tid [POOL];
    logic [6:0]                free_head;
    int                        lost_nodes;

    sem_result_t expected_outcomes [$];
    int          mismatch_count;
    int          idle_pct;

    counting_semaphore_wait_list_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .sem_index    (sem_index),
        .init_value   (init_value),
        .thread_id    (thread_id),
        .done         (done),
        .blocked      (blocked),
        .woke         (woke),
        .woken_thread (woken_thread),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("** counting_semaphore_wait_list_top: FAILED **");
        $finish;
    end

    function automatic void reset_bank_model();
        for (int i = 0; i < SEMS; i++)
        begin
            sem_count[i] = '0;
            wait_head[i] = EMPTY_NODE;
        end
        for (int i = 0; i < POOL; i++)
        begin
            node_next[i] = (i + 1 < POOL) ? 7'(i + 1) : EMPTY_NODE;
            node_tid[i]  = '0;
        end
        free_head  = '0;
        lost_nodes = 0;
    endfunction

    function automatic int chain_length(logic [6:0] n);
        int len;
        len = 0;
        while (n < POOL && len < POOL)
        begin
            n = node_next[n];
            len++;
        end
        return len;
    endfunction

    function automatic sem_result_t predict_semaphore_op(act_t act, logic [3:0] s,
                                                         logic [14:0] ival, logic [7:0] tid);
        sem_result_t              r;
        logic signed [COUNT_W-1:0] nc;
        logic [6:0]               n;
        logic [6:0]               nx;
        int                       steps;
        r = '0;
        case (act)
            ACT_INIT:
            begin
                lost_nodes += chain_length(wait_head[s]);
                sem_count[s] = {1'b0, ival};
                wait_head[s] = EMPTY_NODE;
            end
            ACT_DESTROY:
            begin
                n = wait_head[s];
                wait_head[s] = EMPTY_NODE;
                steps = 0;
                while (n < POOL && steps < POOL)
                begin
                    nx = node_next[n];
                    node_next[n] = free_head;
                    free_head = n;
                    n = nx;
                    steps++;
                end
            end
            ACT_WAIT:
            begin
                nc = (sem_count[s] != COUNT_MIN) ? sem_count[s] - 16'sd1 : COUNT_MIN;
                if (nc >= 0)
                    sem_count[s] = nc;
                else if (free_head >= POOL)
                    r.status = 1'b1;
                else
                begin
                    n = free_head;
                    free_head = node_next[n];
                    node_next[n] = wait_head[s];
                    node_tid[n] = tid;
                    wait_head[s] = n;
                    sem_count[s] = nc;
                    r.blocked = 1'b1;
                end
            end
            default:
            begin
                nc = (sem_count[s] != COUNT_MAX) ? sem_count[s] + 16'sd1 : COUNT_MAX;
                sem_count[s] = nc;
                if (nc <= 0 && wait_head[s] < POOL)
                begin
                    n = wait_head[s];
                    r.woke = 1'b1;
                    r.woken_thread = node_tid[n];
                    wait_head[s] = node_next[n];
                    node_next[n] = free_head;
                    free_head = n;
                end
            end
        endcase
        return r;
    endfunction

    // start is left high after a transfer so back-to-back items need no toggle
    task automatic send_op(input act_t act, input logic [3:0] s,
                           input logic [14:0] ival, input logic [7:0] tid);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        action     <= act;
        sem_index  <= s;
        init_value <= ival;
        thread_id  <= tid;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_outcomes.push_back(predict_semaphore_op(act, s, ival, tid));
    endtask

    task automatic flag_mismatch(input string what, input sem_result_t want,
                                 input sem_result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $write("%0t: %s: expected blocked=%0b woke=%0b thread=%0d status=%0b, ",
                   $realtime, what, want.blocked, want.woke, want.woken_thread,
                   want.status);
            $display("got blocked=%0b woke=%0b thread=%0d status=%0b",
                     got.blocked, got.woke, got.woken_thread, got.status);
        end
    endtask

    always @(posedge clk)
    begin
        sem_result_t got;
        sem_result_t want;
        if (rst_n && done)
        begin
            got = {blocked, woke, woken_thread, status};
            if (expected_outcomes.size() == 0)
                flag_mismatch("result with no transfer pending", '0, got);
            else
            begin
                want = expected_outcomes.pop_front();
                if (got !== want)
                    flag_mismatch("result mismatch", want, got);
            end
        end
    end

    task automatic test_init_limits();
        send_op(ACT_INIT, 4'd0, 15'd0, 8'd0);
        send_op(ACT_INIT, 4'd1, 15'h7FFF, 8'hFF);
        send_op(ACT_POST, 4'd1, 15'h7FFF, 8'hFF);
        send_op(ACT_WAIT, 4'd1, 15'd0, 8'h5A);
        send_op(ACT_WAIT, 4'd0, 15'd0, 8'h00);
        send_op(ACT_POST, 4'd0, 15'd0, 8'h00);
    endtask

    task automatic test_lifo_wake();
        send_op(ACT_INIT, 4'd2, 15'd0, 8'd0);
        send_op(ACT_WAIT, 4'd2, 15'd0, 8'h00);
        send_op(ACT_WAIT, 4'd2, 15'd0, 8'hFF);
        send_op(ACT_WAIT, 4'd2, 15'd0, 8'hA5);
        repeat (4)
            send_op(ACT_POST, 4'd2, 15'd0, 8'd0);
    endtask

    // destroy keeps the negative count, so the next post finds an empty list
    task automatic test_destroy_keeps_count();
        send_op(ACT_DESTROY, 4'd6, 15'd0, 8'd0);
        send_op(ACT_INIT, 4'd3, 15'd0, 8'd0);
        send_op(ACT_WAIT, 4'd3, 15'd0, 8'h11);
        send_op(ACT_WAIT, 4'd3, 15'd0, 8'h22);
        send_op(ACT_DESTROY, 4'd3, 15'd0, 8'd0);
        send_op(ACT_POST, 4'd3, 15'd0, 8'd0);
        send_op(ACT_POST, 4'd3, 15'd0, 8'd0);
    endtask

    task automatic test_init_drops_waiters();
        send_op(ACT_INIT, 4'd4, 15'd0, 8'd0);
        send_op(ACT_WAIT, 4'd4, 15'd0, 8'h33);
        send_op(ACT_WAIT, 4'd4, 15'd0, 8'h44);
        send_op(ACT_INIT, 4'd4, 15'd1, 8'd0);
        send_op(ACT_POST, 4'd4, 15'd0, 8'd0);
    endtask

    task automatic test_pool_exhaustion();
        send_op(ACT_INIT, 4'd5, 15'd0, 8'd0);
        while (chain_length(free_head) > 0)
            send_op(ACT_WAIT, 4'd5, 15'd0, 8'($urandom));
        send_op(ACT_WAIT, 4'd5, 15'd0, 8'hC3);
        send_op(ACT_POST, 4'd5, 15'd0, 8'd0);
        send_op(ACT_WAIT, 4'd5, 15'd0, 8'h3C);
        send_op(ACT_WAIT, 4'd7, 15'd0, 8'h3C);
        send_op(ACT_DESTROY, 4'd5, 15'd0, 8'd0);
        send_op(ACT_INIT, 4'd5, 15'd0, 8'd0);
    endtask

    task automatic run_random(input int n_items, input int idle);
        act_t        a;
        logic [3:0]  s;
        logic [14:0] v;
        int          r;
        idle_pct = idle;
        repeat (n_items)
        begin
            r = $urandom_range(99);
            s = 4'($urandom_range(SEMS - 1));
            v = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(3));
            if (r < 40)
                a = ACT_WAIT;
            else if (r < 80)
                a = ACT_POST;
            else if (r < 92)
                a = ACT_INIT;
            else
                a = ACT_DESTROY;
            // keep leaked nodes bounded, they only come back at reset
            if (a == ACT_INIT && chain_length(wait_head[s]) > 0 && lost_nodes >= LEAK_LIMIT)
                a = ACT_DESTROY;
            send_op(a, s, v, 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        action         <= ACT_INIT;
        sem_index      <= '0;
        init_value     <= '0;
        thread_id      <= '0;
        mismatch_count = 0;
        idle_pct       = 17;
        reset_bank_model();
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_init_limits();
        test_lifo_wake();
        test_destroy_keeps_count();
        test_init_drops_waiters();
        test_pool_exhaustion();
        run_random(440, 17);
        run_random(440, 63);
        run_random(440, 0);

        start <= 1'b0;
        @(posedge clk);
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("** counting_semaphore_wait_list_top: PASSED **");
        else
            $display("** counting_semaphore_wait_list_top: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
rtl/cswl_pkg.sv
rtl/cswl_ctrl.sv
rtl/cswl_datapath.sv
rtl/counting_semaphore_wait_list_top.sv
tb/counting_semaphore_wait_list_top_test.sv
